@@ rtl/evr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_pkg: shared constants for the Euler-angle vector rotator.
// Widths of the fixed-point datapath, the CORDIC arctangent table and the
// pipeline latency.
// ----------------------------------------------------------------------------
package evr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam int ZW  = 36;
    localparam int XW  = 34;
    localparam int SCW = 18;
    localparam int PW  = 36;
    localparam int TW  = 54;
    localparam int MW  = 34;
    localparam int MVW = 50;
    localparam int AW  = 52;

    localparam int CORDIC_LAT = NSTEPS + 2;
    localparam int LATENCY    = CORDIC_LAT + 5;

    localparam logic signed [ZW-1:0] GAIN_INV_Q30 = 36'sd652032874;
    localparam logic signed [ZW-1:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30  = 36'sd1686629713;

    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:       r = 36'sd843314857;
            1:       r = 36'sd497837829;
            2:       r = 36'sd263043837;
            3:       r = 36'sd133525159;
            4:       r = 36'sd67021687;
            5:       r = 36'sd33543516;
            6:       r = 36'sd16775851;
            7:       r = 36'sd8388437;
            8:       r = 36'sd4194283;
            9:       r = 36'sd2097149;
            10:      r = 36'sd1048576;
            11:      r = 36'sd524288;
            12:      r = 36'sd262144;
            13:      r = 36'sd131072;
            14:      r = 36'sd65536;
            15:      r = 36'sd32768;
            16:      r = 36'sd16384;
            17:      r = 36'sd8192;
            18:      r = 36'sd4096;
            19:      r = 36'sd2048;
            20:      r = 36'sd1024;
            21:      r = 36'sd512;
            22:      r = 36'sd256;
            23:      r = 36'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/evr_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_cordic: pipelined CORDIC sine and cosine.
// One register stage for quadrant folding, one per CORDIC step and one for
// the sign restore and rounding to 16 fraction bits.
// ----------------------------------------------------------------------------
module evr_cordic (
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  angle,
    output logic signed [17:0]  sin_out,
    output logic signed [17:0]  cos_out
);
    import evr_pkg::*;

    logic signed [XW-1:0] x_reg [0:NSTEPS];
    logic signed [XW-1:0] y_reg [0:NSTEPS];
    logic signed [ZW-1:0] z_reg [0:NSTEPS];
    logic                 flip_reg [0:NSTEPS];

    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z0_next;
    logic                 flip0_next;
    logic signed [XW-1:0] xf;
    logic signed [XW-1:0] yf;
    logic signed [SCW-1:0] sin_reg;
    logic signed [SCW-1:0] cos_reg;

    always_comb
    begin
        z_in = ZW'(angle) <<< 17;
        z0_next = z_in;
        flip0_next = 1'b0;
        if (z_in > HALF_PI_Q30)
        begin
            z0_next = z_in - PI_Q30;
            flip0_next = 1'b1;
        end
        else if (z_in < -HALF_PI_Q30)
        begin
            z0_next = z_in + PI_Q30;
            flip0_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= XW'(GAIN_INV_Q30);
            y_reg[0] <= '0;
            z_reg[0] <= z0_next;
            flip_reg[0] <= flip0_next;
        end
    end

    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    always_comb
    begin
        xf = flip_reg[NSTEPS] ? -x_reg[NSTEPS] : x_reg[NSTEPS];
        yf = flip_reg[NSTEPS] ? -y_reg[NSTEPS] : y_reg[NSTEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= SCW'((xf + XW'(8192)) >>> 14);
            sin_reg <= SCW'((yf + XW'(8192)) >>> 14);
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

@@ rtl/evr_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_matrix: rotation matrix R = Rz*Ry*Rx from sines and cosines.
// Pairwise products, then triple products, then each entry summed in Q.48
// and rounded once to Q.30; three register stages.
// ----------------------------------------------------------------------------
module evr_matrix (
    input  logic               clk,
    input  logic               en,
    input  logic signed [17:0] sx,
    input  logic signed [17:0] cx,
    input  logic signed [17:0] sy,
    input  logic signed [17:0] cy,
    input  logic signed [17:0] sz,
    input  logic signed [17:0] cz,
    output logic signed [33:0] m_out [0:8]
);
    import evr_pkg::*;

    localparam logic signed [TW-1:0] RND18 = TW'(131072);

    logic signed [PW-1:0] cycz_reg, czsx_reg, cxsz_reg, cxcz_reg, sxsy_reg, cxsy_reg;
    logic signed [PW-1:0] sxsz_reg, cysz_reg, cysx_reg, cxcy_reg;
    logic signed [SCW-1:0] sy1_reg, sz1_reg;

    logic signed [PW-1:0] cycz2_reg, cxsz2_reg, sxsz2_reg, cxcz2_reg, cysz2_reg;
    logic signed [PW-1:0] czsx2_reg, cysx2_reg, cxcy2_reg;
    logic signed [SCW-1:0] sy2_reg;
    logic signed [TW-1:0] t1_reg, t2_reg, t4_reg, t5_reg;

    logic signed [MW-1:0] m_reg [0:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycz_reg <= PW'(cy) * PW'(cz);
            czsx_reg <= PW'(cz) * PW'(sx);
            cxsz_reg <= PW'(cx) * PW'(sz);
            cxcz_reg <= PW'(cx) * PW'(cz);
            sxsy_reg <= PW'(sx) * PW'(sy);
            cxsy_reg <= PW'(cx) * PW'(sy);
            sxsz_reg <= PW'(sx) * PW'(sz);
            cysz_reg <= PW'(cy) * PW'(sz);
            cysx_reg <= PW'(cy) * PW'(sx);
            cxcy_reg <= PW'(cx) * PW'(cy);
            sy1_reg  <= sy;
            sz1_reg  <= sz;

            t1_reg <= TW'(czsx_reg) * TW'(sy1_reg);
            t2_reg <= TW'(cxcz_reg) * TW'(sy1_reg);
            t4_reg <= TW'(sxsy_reg) * TW'(sz1_reg);
            t5_reg <= TW'(cxsy_reg) * TW'(sz1_reg);
            cycz2_reg <= cycz_reg;
            cxsz2_reg <= cxsz_reg;
            sxsz2_reg <= sxsz_reg;
            cxcz2_reg <= cxcz_reg;
            cysz2_reg <= cysz_reg;
            czsx2_reg <= czsx_reg;
            cysx2_reg <= cysx_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg   <= sy1_reg;

            m_reg[0] <= MW'(((TW'(cycz2_reg) <<< 16) + RND18) >>> 18);
            m_reg[1] <= MW'((t1_reg - (TW'(cxsz2_reg) <<< 16) + RND18) >>> 18);
            m_reg[2] <= MW'((t2_reg + (TW'(sxsz2_reg) <<< 16) + RND18) >>> 18);
            m_reg[3] <= MW'(((TW'(cysz2_reg) <<< 16) + RND18) >>> 18);
            m_reg[4] <= MW'(((TW'(cxcz2_reg) <<< 16) + t4_reg + RND18) >>> 18);
            m_reg[5] <= MW'((t5_reg - (TW'(czsx2_reg) <<< 16) + RND18) >>> 18);
            m_reg[6] <= MW'(((-(TW'(sy2_reg)) <<< 32) + RND18) >>> 18);
            m_reg[7] <= MW'(((TW'(cysx2_reg) <<< 16) + RND18) >>> 18);
            m_reg[8] <= MW'(((TW'(cxcy2_reg) <<< 16) + RND18) >>> 18);
        end
    end

    assign m_out = m_reg;

endmodule

@@ rtl/evr_apply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_apply: matrix times vector with rounding and saturation.
// Nine Q.30 by Q.14 products in one stage, row sums rounded to Q.14 and
// saturated into the output register in the next.
// ----------------------------------------------------------------------------
module evr_apply (
    input  logic               clk,
    input  logic               en,
    input  logic signed [33:0] m_in [0:8],
    input  logic signed [15:0] v_in [0:2],
    output logic signed [15:0] r_out [0:2]
);
    import evr_pkg::*;

    localparam logic signed [AW-1:0] RND30 = AW'(64'sd536870912);
    localparam logic signed [AW-31:0] SAT_MAX = (AW-30)'(32767);
    localparam logic signed [AW-31:0] SAT_MIN = -(AW-30)'(32768);

    logic signed [MVW-1:0] p_reg [0:8];
    logic signed [15:0]    r_reg [0:2];
    logic signed [AW-1:0]  acc [0:2];
    logic signed [AW-31:0] rnd [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                p_reg[k] <= MVW'(m_in[k]) * MVW'(v_in[k % 3]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = AW'(p_reg[3*r]) + AW'(p_reg[3*r+1]) + AW'(p_reg[3*r+2]) + RND30;
            rnd[r] = (AW-30)'(acc[r] >>> 30);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (rnd[r] > SAT_MAX)
                    r_reg[r] <= 16'sh7fff;
                else if (rnd[r] < SAT_MIN)
                    r_reg[r] <= -16'sh8000;
                else
                    r_reg[r] <= 16'(rnd[r]);
            end
        end
    end

    assign r_out = r_reg;

endmodule

@@ rtl/euler_xyz_vector_rotate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotate: rotates a Q2.14 vector by Z-Y-X Euler angles.
// Each input transaction carries three Q3.13 angles and one vector; each
// output transaction carries the rotated vector R*v, R = Rz*Ry*Rx,
// rounded and saturated to Q2.14.
//
// Both channels use valid/ready. One transaction per cycle is accepted
// while the output is not stalled. The pipeline has one stage of angle
// folding, one per CORDIC step, one of rounding, three for the matrix
// build and two for the matrix-vector product and saturation. Throughput
// is one transaction per clock unless the receiver stalls; the depth is
// set by the CORDIC step pipeline, three side by side for the three angles.
// Reset clears all valid bits; the datapath holds no state between items.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module euler_xyz_vector_rotate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    input  logic signed [15:0] vec_x,
    input  logic signed [15:0] vec_y,
    input  logic signed [15:0] vec_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] rot_x,
    output logic signed [15:0] rot_y,
    output logic signed [15:0] rot_z
);
    import evr_pkg::*;

    logic                 advance;
    logic [LATENCY-1:0]   valid_reg;
    logic signed [15:0]   vx_reg [0:CORDIC_LAT+2];
    logic signed [15:0]   vy_reg [0:CORDIC_LAT+2];
    logic signed [15:0]   vz_reg [0:CORDIC_LAT+2];
    logic signed [17:0]   sx, cx, sy, cy, sz, cz;
    logic signed [33:0]   m [0:8];
    logic signed [15:0]   v_mat [0:2];
    logic signed [15:0]   r [0:2];

    assign advance  = !valid_reg[LATENCY-1] || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[LATENCY-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vx_reg[0] <= vec_x;
            vy_reg[0] <= vec_y;
            vz_reg[0] <= vec_z;
            for (int k = 1; k <= CORDIC_LAT + 2; k++)
            begin
                vx_reg[k] <= vx_reg[k-1];
                vy_reg[k] <= vy_reg[k-1];
                vz_reg[k] <= vz_reg[k-1];
            end
        end
    end

    evr_cordic u_cordic_x (.clk(clk), .en(advance), .angle(angle_x), .sin_out(sx), .cos_out(cx));
    evr_cordic u_cordic_y (.clk(clk), .en(advance), .angle(angle_y), .sin_out(sy), .cos_out(cy));
    evr_cordic u_cordic_z (.clk(clk), .en(advance), .angle(angle_z), .sin_out(sz), .cos_out(cz));

    evr_matrix u_matrix (
        .clk   (clk),
        .en    (advance),
        .sx    (sx),
        .cx    (cx),
        .sy    (sy),
        .cy    (cy),
        .sz    (sz),
        .cz    (cz),
        .m_out (m)
    );

    assign v_mat[0] = vx_reg[CORDIC_LAT+2];
    assign v_mat[1] = vy_reg[CORDIC_LAT+2];
    assign v_mat[2] = vz_reg[CORDIC_LAT+2];

    evr_apply u_apply (
        .clk   (clk),
        .en    (advance),
        .m_in  (m),
        .v_in  (v_mat),
        .r_out (r)
    );

    assign out_valid = valid_reg[LATENCY-1];
    assign rot_x = r[0];
    assign rot_y = r[1];
    assign rot_z = r[2];

`ifndef SYNTHESIS
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while the output stage is stalled");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("pipeline valid bits moved during a stall");

    a_entry_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transaction not captured in the first stage");
`endif

endmodule

@@ tb/sv/euler_xyz_vector_rotate_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotate_tb: self-checking bench for the Euler rotator.
// A fixed-point CORDIC and matrix predictor computes R*v for every accepted
// transaction; results are compared in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
module euler_xyz_vector_rotate_tb;

    import evr_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec3_t;

    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint PI_VAL    = 64'sd3373259426;
    localparam longint HALF_PI   = 64'sd1686629713;
    localparam int     MAX_STEPS = 24;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] angle_x, angle_y, angle_z, vec_x, vec_y, vec_z;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] rot_x, rot_y, rot_z;

    vec3_t  rotated_q[$];
    int     errors = 0;
    int     sent = 0;
    int     received = 0;
    int     hold_cycles;
    int     wait_cycles;
    bit     hold_req = 1'b0;
    bit     hold_ack;
    bit     stall_enable = 1'b0;

    euler_xyz_vector_rotate uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_off(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    task automatic cordic_sincos(input logic signed [15:0] ang,
                                 output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        longint at;
        bit     flip;
        int     n;
        z = longint'(ang) * 131072;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        n = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
        if (z > HALF_PI)
        begin
            z = z - PI_VAL;
            flip = 1;
        end
        else if (z < -HALF_PI)
        begin
            z = z + PI_VAL;
            flip = 1;
        end
        for (int i = 0; i < n; i++)
        begin
            at = longint'(atan_q30(i));
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z = z - at;
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z = z + at;
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = round_off(x, 14);
        s = round_off(y, 14);
    endtask

    function automatic logic signed [15:0] row_product(longint a, longint b, longint c,
                                                       longint vx, longint vy, longint vz);
        longint r;
        r = round_off(a * vx + b * vy + c * vz, 30);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    task automatic predict_rotation(input logic signed [15:0] ax, ay, az, vx, vy, vz,
                                    output vec3_t res);
        longint sx, cx, sy, cy, sz, cz;
        longint m[9];
        longint k16;
        longint k32;
        k16 = 65536;
        k32 = 64'sd1 <<< 32;
        cordic_sincos(ax, sx, cx);
        cordic_sincos(ay, sy, cy);
        cordic_sincos(az, sz, cz);
        m[0] = round_off(cy * cz * k16, 18);
        m[1] = round_off(cz * sx * sy - cx * sz * k16, 18);
        m[2] = round_off(cx * cz * sy + sx * sz * k16, 18);
        m[3] = round_off(cy * sz * k16, 18);
        m[4] = round_off(cx * cz * k16 + sx * sy * sz, 18);
        m[5] = round_off(cx * sy * sz - cz * sx * k16, 18);
        m[6] = round_off(-sy * k32, 18);
        m[7] = round_off(cy * sx * k16, 18);
        m[8] = round_off(cx * cy * k16, 18);
        res.x = row_product(m[0], m[1], m[2], vx, vy, vz);
        res.y = row_product(m[3], m[4], m[5], vx, vy, vz);
        res.z = row_product(m[6], m[7], m[8], vx, vy, vz);
    endtask

    task automatic send_rotation(input logic signed [15:0] ax, ay, az, vx, vy, vz,
                                 input bit with_gap);
        vec3_t res;
        int    gap;
        gap = with_gap ? int'($urandom_range(0, 7)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        vec_x <= vx;
        vec_y <= vy;
        vec_z <= vz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_rotation(ax, ay, az, vx, vy, vz, res);
        rotated_q.push_back(res);
        sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (rotated_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] ext[6];
        ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh4000, 16'shC000, 16'sh3244};
        send_rotation(16'sh0000, 16'sh0000, 16'sh0000,
                      16'sh4000, 16'sh0000, 16'sh0000, 0);
        send_rotation(16'sh3244, 16'sh0000, 16'sh0000,
                      16'sh0000, 16'sh4000, 16'sh0000, 0);
        send_rotation(16'sh0000, 16'sh3244, 16'sh0000,
                      16'sh4000, 16'sh0000, 16'sh4000, 0);
        send_rotation(16'sh0000, 16'sh0000, 16'sh3244,
                      16'sh4000, 16'sh4000, 16'sh0000, 0);
        for (int i = 0; i < 6; i++)
            send_rotation(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6],
                          16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_rotation(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 0);
        send_rotation(16'sh1921, 16'sh1921, 16'sh1921, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_rotation(16'sh3245, 16'shCDBB, 16'sh3243, 16'sh8000, 16'sh0001, 16'shFFFF, 0);
        send_rotation(16'shCDBC, 16'sh3244, 16'shCDBC, 16'sh5A82, 16'sh5A82, 16'sh5A82, 0);
        drop_valid();
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_rotation(rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word(), 1);
        drop_valid();
    endtask

    task automatic test_backpressure();
        hold_req = ~hold_req;
        for (int i = 0; i < 50; i++)
            send_rotation(rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word(), 0);
        drop_valid();
        wait_drained();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : receiver
        int draw;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cycles <= 0;
            wait_cycles <= 0;
            hold_ack <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_cycles <= 60;
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else if (wait_cycles > 0)
        begin
            wait_cycles <= wait_cycles - 1;
            out_ready <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            draw = stall_enable ? int'($urandom_range(0, 7)) : 0;
            out_ready <= (draw == 0);
            wait_cycles <= (draw > 0) ? draw - 1 : 0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        vec3_t want;
        if (rst_n && out_valid && out_ready)
        begin
            received++;
            if (rotated_q.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d z=%0d", rot_x, rot_y, rot_z);
                errors++;
            end
            else
            begin
                want = rotated_q.pop_front();
                if (rot_x !== want.x)
                begin
                    $error("rot_x expected %0d actual %0d", want.x, rot_x);
                    errors++;
                end
                if (rot_y !== want.y)
                begin
                    $error("rot_y expected %0d actual %0d", want.y, rot_y);
                    errors++;
                end
                if (rot_z !== want.z)
                begin
                    $error("rot_z expected %0d actual %0d", want.z, rot_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("euler_xyz_vector_rotate_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        angle_x = '0;
        angle_y = '0;
        angle_z = '0;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        stall_enable = 1;
        test_random(800);
        wait_drained();
        stall_enable = 0;
        test_random(750);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (rotated_q.size() != 0)
            $error("%0d expected results never arrived", rotated_q.size());
        $display("Sent %0d transactions and checked %0d results, with gaps and stalls.",
                 sent, received);
        $display("Extreme angles, saturating vectors and a long output hold were included.");
        if (errors == 0 && rotated_q.size() == 0)
            $display("euler_xyz_vector_rotate_tb OK");
        else
            $display("euler_xyz_vector_rotate_tb NOT OK");
        $finish;
    end

endmodule
